// File: design/ieh_pkg.sv
// Shared types, codes and constants of the IEEE-488 device handshake block.
package ieh_pkg;

  // Default depth of the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // Bit positions in the pull-low and output-enable registers.
  localparam int unsigned BitNdac = 0;
  localparam int unsigned BitNrfd = 1;
  localparam int unsigned BitDav  = 2;
  localparam int unsigned BitEoi  = 3;
  localparam int unsigned BitData = 4;

  // Bus command codes.
  typedef enum logic [3:0] {
    CMD_TICK   = 4'd0,
    CMD_RDADDR = 4'd1,
    CMD_ACCEPT = 4'd2,
    CMD_REJECT = 4'd3,
    CMD_BTALK  = 4'd4,
    CMD_SEND   = 4'd5,
    CMD_ETALK  = 4'd6,
    CMD_RECV   = 4'd7,
    CMD_ACK    = 4'd8
  } cmd_e;

  // Handshake phases, one-hot.
  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_RA_ATN  = 11'b000_0000_0010,
    PH_RA_DAV  = 11'b000_0000_0100,
    PH_AC_DAV  = 11'b000_0000_1000,
    PH_RJ_ATN  = 11'b000_0001_0000,
    PH_BT_ATN  = 11'b000_0010_0000,
    PH_BT_NDAC = 11'b000_0100_0000,
    PH_SD_NRFD = 11'b000_1000_0000,
    PH_SD_NDAC = 11'b001_0000_0000,
    PH_RX_DAV  = 11'b010_0000_0000,
    PH_AK_DAV  = 11'b100_0000_0000
  } phase_e;

  // Input word as it arrives on the request channel.
  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       atn_line;
    logic       dav_line;
    logic       nrfd_line;
    logic       ndac_line;
    logic       eoi_line;
    logic [7:0] bus_data_in;
  } ieh_in_t;

  // Result word on the response channel.
  typedef struct packed {
    logic [3:0] line_low;
    logic [4:0] line_enable;
    logic [7:0] bus_data_out;
    logic [7:0] rx_byte;
    logic [3:0] device_address;
    logic [3:0] address_group;
    logic       atn_flag;
    logic       eoi_flag;
    logic       busy_res;
    logic       done_res;
    logic       unlistened;
  } ieh_out_t;

  // Classified word held in the queue.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       atn_line;
    logic       dav_line;
    logic       nrfd_line;
    logic       ndac_line;
    logic       eoi_line;
    logic [7:0] bus_data_in;
  } ieh_entry_t;

endpackage

// File: design/ieh_in_if.sv
// Request channel: valid/ready handshake carrying one input word.
interface ieh_in_if import ieh_pkg::*; ();
  logic    valid;
  logic    ready;
  ieh_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/ieh_out_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface ieh_out_if import ieh_pkg::*; ();
  logic     valid;
  logic     ready;
  ieh_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/ieh_front.sv
// Front part: takes request words and classifies the command code.
module ieh_front import ieh_pkg::*; (
  ieh_in_if.sink     req_i,
  input  logic       q_full_i,
  output logic       push_o,
  output ieh_entry_t entry_o
);

  cmd_e cmd_class;

  // Map the raw code onto a known command; unused codes act as tick
  always_comb begin
    unique case (req_i.data.cmd)
      4'd1:    cmd_class = CMD_RDADDR;
      4'd2:    cmd_class = CMD_ACCEPT;
      4'd3:    cmd_class = CMD_REJECT;
      4'd4:    cmd_class = CMD_BTALK;
      4'd5:    cmd_class = CMD_SEND;
      4'd6:    cmd_class = CMD_ETALK;
      4'd7:    cmd_class = CMD_RECV;
      4'd8:    cmd_class = CMD_ACK;
      default: cmd_class = CMD_TICK;
    endcase
  end

  // Accept whenever the queue has room
  assign req_i.ready = ~q_full_i;
  assign push_o      = req_i.valid & ~q_full_i;

  // Build the queue entry
  always_comb begin
    entry_o.cmd         = cmd_class;
    entry_o.tx_byte     = req_i.data.tx_byte;
    entry_o.tx_last     = req_i.data.tx_last;
    entry_o.atn_line    = req_i.data.atn_line;
    entry_o.dav_line    = req_i.data.dav_line;
    entry_o.nrfd_line   = req_i.data.nrfd_line;
    entry_o.ndac_line   = req_i.data.ndac_line;
    entry_o.eoi_line    = req_i.data.eoi_line;
    entry_o.bus_data_in = req_i.data.bus_data_in;
  end

endmodule

// File: design/ieh_queue.sv
// Short FIFO of classified words between the front and back parts.
module ieh_queue import ieh_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ieh_entry_t entry_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output ieh_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ieh_entry_t     store_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = store_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Write the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= entry_i;
    end
  end

endmodule

// File: design/ieh_back.sv
// Back part: runs the three-wire handshake phases and registers each result word.
module ieh_back import ieh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  ieh_entry_t head_i,
  output logic       pop_o,
  ieh_out_if.source  rsp_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_tx_byte_q, held_tx_byte_d;
  logic       held_tx_last_q, held_tx_last_d;
  logic [7:0] received_byte_q, received_byte_d;
  logic [7:0] address_byte_q, address_byte_d;
  logic       atn_seen_q, atn_seen_d;
  logic       eoi_seen_q, eoi_seen_d;
  logic       released_q, released_d;
  logic [3:0] drive_low_q, drive_low_d;
  logic [4:0] drive_enable_q, drive_enable_d;
  logic       done;
  logic       out_valid_q;
  ieh_out_t   out_q, out_d;

  // Take the next word when the output slot is free or being drained
  assign pop_o = q_valid_i & (~out_valid_q | rsp_o.ready);

  // Start a command, then test the current phase's wait condition
  always_comb begin
    phase_d         = phase_q;
    held_tx_byte_d  = held_tx_byte_q;
    held_tx_last_d  = held_tx_last_q;
    received_byte_d = received_byte_q;
    address_byte_d  = address_byte_q;
    atn_seen_d      = atn_seen_q;
    eoi_seen_d      = eoi_seen_q;
    released_d      = released_q;
    drive_low_d     = drive_low_q;
    drive_enable_d  = drive_enable_q;
    done            = 1'b0;

    if (phase_q == PH_IDLE) begin
      unique case (head_i.cmd)
        CMD_RDADDR: phase_d = PH_RA_ATN;
        CMD_ACCEPT: begin
          drive_low_d[BitNdac] = 1'b0;
          phase_d = PH_AC_DAV;
        end
        CMD_REJECT: begin
          drive_enable_d = '0;
          released_d     = 1'b1;
          phase_d        = PH_RJ_ATN;
        end
        CMD_BTALK: begin
          drive_enable_d[BitNrfd] = 1'b0;
          phase_d = PH_BT_ATN;
        end
        CMD_SEND: begin
          held_tx_byte_d = head_i.tx_byte;
          held_tx_last_d = head_i.tx_last;
          phase_d        = PH_SD_NRFD;
        end
        CMD_ETALK: begin
          drive_enable_d[BitNdac] = 1'b1;
          drive_low_d[BitNdac]    = 1'b1;
          drive_enable_d[BitDav]  = 1'b0;
          drive_enable_d[BitEoi]  = 1'b0;
          drive_enable_d[BitData] = 1'b0;
          drive_enable_d[BitNrfd] = 1'b1;
          drive_low_d[BitNrfd]    = 1'b0;
          done = 1'b1;
        end
        CMD_RECV: phase_d = PH_RX_DAV;
        CMD_ACK: begin
          drive_low_d[BitNrfd] = 1'b1;
          drive_low_d[BitNdac] = 1'b0;
          phase_d = PH_AK_DAV;
        end
        default: ;
      endcase
    end

    unique case (phase_d)
      PH_IDLE: ;
      PH_RA_ATN: begin
        if (!head_i.atn_line) begin
          drive_enable_d[BitNdac] = 1'b1;
          drive_low_d[BitNdac]    = 1'b1;
          phase_d = PH_RA_DAV;
        end
      end
      PH_RA_DAV: begin
        if (!head_i.dav_line) begin
          address_byte_d          = ~head_i.bus_data_in;
          drive_enable_d[BitNrfd] = 1'b1;
          drive_low_d[BitNrfd]    = 1'b1;
          drive_low_d[BitNdac]    = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_AC_DAV: begin
        if (head_i.dav_line) begin
          drive_low_d[BitNrfd] = 1'b0;
          drive_low_d[BitNdac] = 1'b1;
          released_d = 1'b0;
          phase_d    = PH_IDLE;
          done       = 1'b1;
        end
      end
      PH_RJ_ATN: begin
        if (head_i.atn_line) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_BT_ATN: begin
        if (head_i.atn_line) begin
          drive_enable_d[BitNdac] = 1'b0;
          drive_enable_d[BitDav]  = 1'b1;
          drive_enable_d[BitEoi]  = 1'b1;
          drive_enable_d[BitData] = 1'b1;
          drive_low_d[BitDav]     = 1'b0;
          drive_low_d[BitEoi]     = 1'b0;
          phase_d = PH_BT_NDAC;
        end
      end
      PH_BT_NDAC: begin
        if (!head_i.ndac_line) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_SD_NRFD: begin
        if (head_i.nrfd_line) begin
          if (held_tx_last_d) begin
            drive_low_d[BitEoi] = 1'b1;
          end
          drive_low_d[BitDav] = 1'b1;
          phase_d = PH_SD_NDAC;
        end
      end
      PH_SD_NDAC: begin
        if (head_i.ndac_line) begin
          drive_low_d[BitDav] = 1'b0;
          drive_low_d[BitEoi] = 1'b0;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_RX_DAV: begin
        if (!head_i.dav_line) begin
          drive_low_d[BitNdac] = 1'b1;
          drive_low_d[BitNrfd] = 1'b1;
          received_byte_d      = ~head_i.bus_data_in;
          atn_seen_d           = ~head_i.atn_line;
          eoi_seen_d           = ~head_i.eoi_line;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      PH_AK_DAV: begin
        if (head_i.dav_line) begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Assemble the result word from the updated state
  always_comb begin
    out_d.line_low       = drive_low_d & drive_enable_d[3:0];
    out_d.line_enable    = drive_enable_d;
    out_d.bus_data_out   = drive_enable_d[BitData] ? ~held_tx_byte_d : 8'h00;
    out_d.rx_byte        = received_byte_d;
    out_d.device_address = address_byte_d[3:0];
    out_d.address_group  = address_byte_d[7:4];
    out_d.atn_flag       = atn_seen_d;
    out_d.eoi_flag       = eoi_seen_d;
    out_d.busy_res       = (phase_d != PH_IDLE);
    out_d.done_res       = done;
    out_d.unlistened     = released_d;
  end

  // Hold handshake state; advance only on a taken word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      held_tx_byte_q  <= '0;
      held_tx_last_q  <= 1'b0;
      received_byte_q <= '0;
      address_byte_q  <= '0;
      atn_seen_q      <= 1'b0;
      eoi_seen_q      <= 1'b0;
      released_q      <= 1'b0;
      drive_low_q     <= '0;
      drive_enable_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q         <= phase_d;
        held_tx_byte_q  <= held_tx_byte_d;
        held_tx_last_q  <= held_tx_last_d;
        received_byte_q <= received_byte_d;
        address_byte_q  <= address_byte_d;
        atn_seen_q      <= atn_seen_d;
        eoi_seen_q      <= eoi_seen_d;
        released_q      <= released_d;
        drive_low_q     <= drive_low_d;
        drive_enable_q  <= drive_enable_d;
        out_valid_q     <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q     <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// File: design/ieee488_device_handshake.sv
// Top level of the IEEE-488 device handshake: front classifier, queue, back sequencer.
// A word's result is valid in the cycle after it leaves the queue; from acceptance it passes
// the queue register, then the output register.
// Throughput: one word per cycle while the response channel takes each result word.
// Reset (rst_ni low, asynchronous): phase idle, all lines released and undriven,
// held and received bytes cleared, queue and output register empty.
module ieee488_device_handshake import ieh_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ieh_in_if.sink    req_i,
  ieh_out_if.source rsp_o
);

  logic       q_full;
  logic       push;
  logic       pop;
  logic       q_valid;
  ieh_entry_t push_entry;
  ieh_entry_t head_entry;

  ieh_front u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  ieh_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_entry)
  );

  ieh_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head_entry),
    .pop_o     (pop),
    .rsp_o     (rsp_o)
  );

endmodule

// File: test/ieee488_device_handshake_tb.sv
// Testbench for the IEEE-488 device handshake: directed and random words checked against a predictor.
module ieee488_device_handshake_tb;
  import ieh_pkg::*;

  // Command codes past the last defined one act as a tick.
  localparam logic [3:0] CmdUnknownLo = 4'd9;
  localparam logic [3:0] CmdUnknownHi = 4'd15;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ieh_in_if  req ();
  ieh_out_if rsp ();

  ieee488_device_handshake dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Predicted device state.
  phase_e     hs_phase;
  logic [7:0] tx_hold;
  logic       tx_last_hold;
  logic [7:0] rx_hold;
  logic [7:0] addr_hold;
  logic       atn_seen;
  logic       eoi_seen;
  logic       released;
  logic [3:0] pull_low;
  logic [4:0] out_en;

  ieh_out_t bus_results_due[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;

  // Clock: 12 time units per period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("ieee488_device_handshake_tb: errors");
      $finish;
    end
  end

  // Stall the result channel at the current rate.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("mismatch %s: got %0h want %0h (cycle %0d)", field, got, want, cycle_count);
  endtask

  task automatic clear_device_state();
    hs_phase     = PH_IDLE;
    tx_hold      = '0;
    tx_last_hold = 1'b0;
    rx_hold      = '0;
    addr_hold    = '0;
    atn_seen     = 1'b0;
    eoi_seen     = 1'b0;
    released     = 1'b0;
    pull_low     = '0;
    out_en       = '0;
  endtask

  // Advance the device by one sampled word and return its line outputs.
  function automatic ieh_out_t handshake_step(input ieh_in_t w);
    ieh_out_t r;
    logic     done;
    done = 1'b0;
    // Start a command only from idle; run its actions before the first wait.
    if (hs_phase == PH_IDLE) begin
      case (w.cmd)
        CMD_RDADDR: hs_phase = PH_RA_ATN;
        CMD_ACCEPT: begin
          pull_low[BitNdac] = 1'b0;
          hs_phase = PH_AC_DAV;
        end
        CMD_REJECT: begin
          out_en   = '0;
          released = 1'b1;
          hs_phase = PH_RJ_ATN;
        end
        CMD_BTALK: begin
          out_en[BitNrfd] = 1'b0;
          hs_phase = PH_BT_ATN;
        end
        CMD_SEND: begin
          tx_hold      = w.tx_byte;
          tx_last_hold = w.tx_last;
          hs_phase     = PH_SD_NRFD;
        end
        CMD_ETALK: begin
          out_en[BitNdac]   = 1'b1;
          pull_low[BitNdac] = 1'b1;
          out_en[BitDav]    = 1'b0;
          out_en[BitEoi]    = 1'b0;
          out_en[BitData]   = 1'b0;
          out_en[BitNrfd]   = 1'b1;
          pull_low[BitNrfd] = 1'b0;
          done = 1'b1;
        end
        CMD_RECV: hs_phase = PH_RX_DAV;
        CMD_ACK: begin
          pull_low[BitNrfd] = 1'b1;
          pull_low[BitNdac] = 1'b0;
          hs_phase = PH_AK_DAV;
        end
        default: ;
      endcase
    end
    // Test the wait of the current phase; at most one passes.
    case (hs_phase)
      PH_IDLE: ;
      PH_RA_ATN:
        if (!w.atn_line) begin
          out_en[BitNdac]   = 1'b1;
          pull_low[BitNdac] = 1'b1;
          hs_phase = PH_RA_DAV;
        end
      PH_RA_DAV:
        if (!w.dav_line) begin
          addr_hold         = ~w.bus_data_in;
          out_en[BitNrfd]   = 1'b1;
          pull_low[BitNrfd] = 1'b1;
          pull_low[BitNdac] = 1'b0;
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_AC_DAV:
        if (w.dav_line) begin
          pull_low[BitNrfd] = 1'b0;
          pull_low[BitNdac] = 1'b1;
          released = 1'b0;
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_RJ_ATN:
        if (w.atn_line) begin
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_BT_ATN:
        if (w.atn_line) begin
          out_en[BitNdac]  = 1'b0;
          out_en[BitDav]   = 1'b1;
          out_en[BitEoi]   = 1'b1;
          out_en[BitData]  = 1'b1;
          pull_low[BitDav] = 1'b0;
          pull_low[BitEoi] = 1'b0;
          hs_phase = PH_BT_NDAC;
        end
      PH_BT_NDAC:
        if (!w.ndac_line) begin
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_SD_NRFD:
        if (w.nrfd_line) begin
          if (tx_last_hold) pull_low[BitEoi] = 1'b1;
          pull_low[BitDav] = 1'b1;
          hs_phase = PH_SD_NDAC;
        end
      PH_SD_NDAC:
        if (w.ndac_line) begin
          pull_low[BitDav] = 1'b0;
          pull_low[BitEoi] = 1'b0;
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_RX_DAV:
        if (!w.dav_line) begin
          pull_low[BitNdac] = 1'b1;
          pull_low[BitNrfd] = 1'b1;
          rx_hold  = ~w.bus_data_in;
          atn_seen = !w.atn_line;
          eoi_seen = !w.eoi_line;
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      PH_AK_DAV:
        if (w.dav_line) begin
          hs_phase = PH_IDLE;
          done = 1'b1;
        end
      default: hs_phase = PH_IDLE;
    endcase
    // Hide pull-low bits of lines that are not driven.
    r.line_low       = pull_low & out_en[3:0];
    r.line_enable    = out_en;
    r.bus_data_out   = out_en[BitData] ? ~tx_hold : 8'h00;
    r.rx_byte        = rx_hold;
    r.device_address = addr_hold[3:0];
    r.address_group  = addr_hold[7:4];
    r.atn_flag       = atn_seen;
    r.eoi_flag       = eoi_seen;
    r.busy_res       = (hs_phase != PH_IDLE);
    r.done_res       = done;
    r.unlistened     = released;
    return r;
  endfunction

  function automatic ieh_in_t bus_word(input logic [3:0] cmd, input logic [7:0] tx,
                                       input logic last, input logic atn, input logic dav,
                                       input logic nrfd, input logic ndac, input logic eoi,
                                       input logic [7:0] din);
    ieh_in_t w;
    w.cmd         = cmd;
    w.tx_byte     = tx;
    w.tx_last     = last;
    w.atn_line    = atn;
    w.dav_line    = dav;
    w.nrfd_line   = nrfd;
    w.ndac_line   = ndac;
    w.eoi_line    = eoi;
    w.bus_data_in = din;
    return w;
  endfunction

  // Offer one word, hold it until taken, and queue its predicted result.
  task automatic send_word(input ieh_in_t w, output ieh_out_t predicted);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= w;
    do @(posedge clk_i); while (!req.ready);
    predicted = handshake_step(w);
    bus_results_due.push_back(predicted);
  endtask

  task automatic send(input ieh_in_t w);
    ieh_out_t p;
    send_word(w, p);
  endtask

  // Check each returned word against the oldest prediction.
  always @(posedge clk_i) begin : check_words
    ieh_out_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (bus_results_due.size() == 0) begin
        report_mismatch("unexpected word", 8'h00, 8'h00);
      end else begin
        want = bus_results_due.pop_front();
        if (rsp.data.line_low !== want.line_low)
          report_mismatch("line_low", 8'(rsp.data.line_low), 8'(want.line_low));
        if (rsp.data.line_enable !== want.line_enable)
          report_mismatch("line_enable", 8'(rsp.data.line_enable), 8'(want.line_enable));
        if (rsp.data.bus_data_out !== want.bus_data_out)
          report_mismatch("bus_data_out", rsp.data.bus_data_out, want.bus_data_out);
        if (rsp.data.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", rsp.data.rx_byte, want.rx_byte);
        if (rsp.data.device_address !== want.device_address)
          report_mismatch("device_address", 8'(rsp.data.device_address),
                          8'(want.device_address));
        if (rsp.data.address_group !== want.address_group)
          report_mismatch("address_group", 8'(rsp.data.address_group),
                          8'(want.address_group));
        if (rsp.data.atn_flag !== want.atn_flag)
          report_mismatch("atn_flag", 8'(rsp.data.atn_flag), 8'(want.atn_flag));
        if (rsp.data.eoi_flag !== want.eoi_flag)
          report_mismatch("eoi_flag", 8'(rsp.data.eoi_flag), 8'(want.eoi_flag));
        if (rsp.data.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(rsp.data.busy_res), 8'(want.busy_res));
        if (rsp.data.done_res !== want.done_res)
          report_mismatch("done_res", 8'(rsp.data.done_res), 8'(want.done_res));
        if (rsp.data.unlistened !== want.unlistened)
          report_mismatch("unlistened", 8'(rsp.data.unlistened), 8'(want.unlistened));
      end
    end
  end

  // Walk each command but reject through its waits, with byte and nibble extremes.
  task automatic test_command_sequences();
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    // read address: ATN not yet low, then ATN low, then DAV low
    send(bus_word(CMD_RDADDR, 8'h00, 0, 1, 0, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 0, 0, 1, 1, 1, 8'hFF));
    send(bus_word(CMD_TICK,   8'h00, 0, 0, 0, 1, 1, 1, 8'h00));
    send(bus_word(CMD_RDADDR, 8'h00, 0, 0, 0, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 0, 0, 1, 1, 1, 8'hFF));
    // accept: DAV still low, then released
    send(bus_word(CMD_ACCEPT, 8'h00, 0, 1, 0, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    // receive with ATN and EOI asserted, then with both released
    send(bus_word(CMD_RECV,   8'h00, 0, 0, 1, 1, 1, 0, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 0, 0, 1, 1, 0, 8'h00));
    send(bus_word(CMD_RECV,   8'h00, 0, 1, 0, 1, 1, 1, 8'hFF));
    send(bus_word(CMD_ACK,    8'h00, 0, 1, 0, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    // begin talk: only one wait passes per word
    send(bus_word(CMD_BTALK,  8'h00, 0, 0, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 0, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 0, 1, 8'h00));
    // send the last byte, then a plain one
    send(bus_word(CMD_SEND,   8'hFF, 1, 1, 1, 0, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 0, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_SEND,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_TICK,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_ETALK,  8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
  endtask

  // Drop commands while busy and treat unknown codes as ticks.
  task automatic test_busy_and_unknown_codes();
    send(bus_word(CMD_REJECT,   8'h00, 0, 0, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_RECV,     8'h00, 0, 0, 0, 1, 1, 0, 8'h00));
    send(bus_word(CmdUnknownLo, 8'hFF, 1, 0, 0, 0, 0, 0, 8'hFF));
    send(bus_word(CmdUnknownHi, 8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CmdUnknownHi, 8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
    send(bus_word(CMD_ACCEPT,   8'h00, 0, 1, 1, 1, 1, 1, 8'h00));
  endtask

  // Random commands and line levels, a fixed number of words.
  task automatic test_random_traffic(input int unsigned n_words);
    int unsigned pick;
    logic [3:0]  cmd;
    repeat (n_words) begin
      pick = $urandom_range(99);
      if (pick < 45)      cmd = 4'($urandom_range(CMD_RDADDR, CMD_ACK));
      else if (pick < 52) cmd = 4'($urandom_range(CmdUnknownLo, CmdUnknownHi));
      else                cmd = CMD_TICK;
      send(bus_word(cmd, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    req.valid <= 1'b0;
    req.data  <= '0;
    clear_device_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = 19;
    sink_idle_pct = 70;
    test_command_sequences();
    test_busy_and_unknown_codes();
    test_random_traffic(570);

    src_idle_pct  = 70;
    sink_idle_pct = 19;
    test_random_traffic(570);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(570);
    req.valid <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (bus_results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ieee488_device_handshake_tb: clean");
    end else begin
      $display("ieee488_device_handshake_tb: errors");
    end
    $finish;
  end

endmodule
